>>> hdl/cva_pkg.sv
// ----------------------------------------------------------------------------
// cva_pkg: shared definitions for the CORDIC vectoring arctangent
// Fixed-point widths, the arctangent table and the data bundle that is passed
// from one iteration cell to the next.
// ----------------------------------------------------------------------------
package cva_pkg;

    localparam int ITERATIONS = 16;
    localparam int FRAC_BITS  = 20;
    localparam int IO_FRAC    = 20;
    localparam int TABLE_FRAC = 30;
    localparam int TABLE_LEN  = 24;
    localparam int FIELD_BITS = 22;

    // Steps beyond the length of the angle table are not performed.
    localparam int NUM_CELLS = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int SH_W      = $clog2(NUM_CELLS);

    // Coordinates grow by the CORDIC gain (about 1.65) on top of a magnitude
    // of up to twice full scale, so four integer bits and a sign suffice.
    localparam int XY_W = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS + 5 : 25;
    // The angle stays below two radians in magnitude.
    localparam int Z_W  = FRAC_BITS + 3;

    localparam int IN_DATA_W  = ((2 * FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((FIELD_BITS + 7) / 8) * 8;

    // atan(2^-i) in Q30, truncated
    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    localparam int TABLE_SHIFT = TABLE_FRAC - FRAC_BITS;

    typedef logic signed [XY_W-1:0] cva_xy_t;
    typedef logic signed [Z_W-1:0]  cva_z_t;

    typedef struct packed {
        cva_xy_t x;
        cva_xy_t y;
        cva_z_t  z;
    } cva_vec_t;

    // Table entry scaled to the internal format, rounding half up.
    function automatic cva_z_t atan_entry(input int idx);
        logic [63:0] t;
        t = {32'd0, ATAN_Q30[idx]};
        if (TABLE_SHIFT > 0)
        begin
            t = (t + (64'd1 << (TABLE_SHIFT - 1))) >> TABLE_SHIFT;
        end
        return t[Z_W-1:0];
    endfunction

endpackage

>>> hdl/cva_cell.sv
// ----------------------------------------------------------------------------
// cva_cell: one CORDIC vectoring iteration
// Rotates the incoming vector towards the x axis by atan(2^-shift) and registers
// the result, with an elastic valid/ready link on either side.
// ----------------------------------------------------------------------------
module cva_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cva_pkg::cva_vec_t        in_data,
    input  logic [cva_pkg::SH_W-1:0] shift,
    input  cva_pkg::cva_z_t          angle_step,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cva_pkg::cva_vec_t        out_data
);
    import cva_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    cva_vec_t data_reg;
    cva_vec_t data_next;
    cva_xy_t  x_cur;
    cva_xy_t  y_cur;
    cva_z_t   z_cur;
    cva_xy_t  dx;
    cva_xy_t  dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_cur = in_data.x;
        y_cur = in_data.y;
        z_cur = in_data.z;
        dx    = y_cur >>> shift;
        dy    = x_cur >>> shift;
        if (y_cur < 0)
        begin
            data_next.x = x_cur - dx;
            data_next.y = y_cur + dy;
            data_next.z = z_cur - angle_step;
        end
        else
        begin
            data_next.x = x_cur + dx;
            data_next.y = y_cur - dy;
            data_next.z = z_cur + angle_step;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/cordic_vectoring_arctan.sv
// ----------------------------------------------------------------------------
// cordic_vectoring_arctan: pipelined CORDIC arctangent
// Returns atan(y/x) in Q20 radians for each (x, y) vector, without quadrant
// correction for negative x.
// ----------------------------------------------------------------------------
// A new vector is taken every clock cycle unless a stall holds off the input. Each vector passes
// through a row of NUM_CELLS iteration cells (16 by default) and then an output register.
// The first cell registers the vector at the edge of the input transaction; its angle then
// moves through the remaining cells and the output register, where it appears on m_tdata.
// Every cell and the output register is an elastic stage: a stall on the
// output side fills empty stages first and only then holds off the input.
module cordic_vectoring_arctan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x_in [21:0], y_in [43:22], zero padding above
    input  logic [cva_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // angle [21:0], zero padding above
    output logic [cva_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cva_pkg::*;

    localparam int R_W = Z_W + IO_FRAC + 1;
    localparam logic signed [R_W-1:0] SAT_MAX = R_W'((1 <<< (FIELD_BITS - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_MIN = -R_W'(1 <<< (FIELD_BITS - 1));

    logic signed [FIELD_BITS-1:0] x_in;
    logic signed [FIELD_BITS-1:0] y_in;
    cva_xy_t                      x_int;
    cva_xy_t                      y_int;

    logic     cell_in_valid [NUM_CELLS+1];
    logic     cell_in_ready [NUM_CELLS+1];
    cva_vec_t cell_data     [NUM_CELLS+1];
    logic [NUM_CELLS-1:0] cell_valid;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [FIELD_BITS-1:0] angle_reg;
    logic signed [FIELD_BITS-1:0] angle_next;
    logic signed [R_W-1:0]        z_wide;
    logic signed [R_W-1:0]        z_scaled;
    logic                         last_ready;

    assign x_in = s_tdata[FIELD_BITS-1:0];
    assign y_in = s_tdata[2*FIELD_BITS-1:FIELD_BITS];

    generate
        if (FRAC_BITS >= IO_FRAC)
        begin : g_in_up
            assign x_int = {{(XY_W-FIELD_BITS){x_in[FIELD_BITS-1]}}, x_in} <<<
                           (FRAC_BITS - IO_FRAC);
            assign y_int = {{(XY_W-FIELD_BITS){y_in[FIELD_BITS-1]}}, y_in} <<<
                           (FRAC_BITS - IO_FRAC);
        end
        else
        begin : g_in_down
            assign x_int = cva_xy_t'({{(XY_W-FIELD_BITS){x_in[FIELD_BITS-1]}}, x_in}) >>>
                           (IO_FRAC - FRAC_BITS);
            assign y_int = cva_xy_t'({{(XY_W-FIELD_BITS){y_in[FIELD_BITS-1]}}, y_in}) >>>
                           (IO_FRAC - FRAC_BITS);
        end
    endgenerate

    assign cell_in_valid[0] = s_tvalid;
    assign s_tready         = cell_in_ready[0];
    assign cell_data[0].x   = x_int;
    assign cell_data[0].y   = y_int;
    assign cell_data[0].z   = '0;

    generate
        for (genvar i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            cva_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (cell_in_valid[i]),
                .in_ready   (cell_in_ready[i]),
                .in_data    (cell_data[i]),
                .shift      (SH_W'(i)),
                .angle_step (atan_entry(i)),
                .out_valid  (cell_in_valid[i+1]),
                .out_ready  (cell_in_ready[i+1]),
                .out_data   (cell_data[i+1])
            );
            assign cell_valid[i] = cell_in_valid[i+1];
        end
    endgenerate

    // Output stage: back to Q20 with saturation to the field width.
    assign last_ready               = !m_valid_reg || m_tready;
    assign cell_in_ready[NUM_CELLS] = last_ready;
    assign z_wide = {{(R_W-Z_W){cell_data[NUM_CELLS].z[Z_W-1]}}, cell_data[NUM_CELLS].z};

    generate
        if (FRAC_BITS > IO_FRAC)
        begin : g_out_down
            assign z_scaled = (z_wide + (R_W'(1) <<< (FRAC_BITS - IO_FRAC - 1))) >>>
                              (FRAC_BITS - IO_FRAC);
        end
        else
        begin : g_out_up
            assign z_scaled = z_wide <<< (IO_FRAC - FRAC_BITS);
        end
    endgenerate

    always_comb
    begin
        if (z_scaled > SAT_MAX)
        begin
            angle_next = SAT_MAX[FIELD_BITS-1:0];
        end
        else if (z_scaled < SAT_MIN)
        begin
            angle_next = SAT_MIN[FIELD_BITS-1:0];
        end
        else
        begin
            angle_next = z_scaled[FIELD_BITS-1:0];
        end
        m_valid_next = last_ready ? cell_in_valid[NUM_CELLS] : m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && cell_in_valid[NUM_CELLS])
        begin
            angle_reg <= angle_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-FIELD_BITS){1'b0}}, angle_reg};

    // With the output register empty, every stage can move, so input is open.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held off although the output register is empty");

    // Under an output stall, input may be taken only while some cell is empty.
    a_ready_needs_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid && !m_tready) |-> ($countones(cell_valid) < NUM_CELLS))
        else $error("input taken while every cell is occupied and the output stalls");

    // A transaction leaving the last cell lands in the output register.
    a_last_cell_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_in_valid[NUM_CELLS] && last_ready) |=> m_tvalid)
        else $error("result from the last cell was lost");

endmodule
